/* hw/rtl/gffr_pkg.sv */
// Shared constants, types and codes of the grid flood fill reach counter.
// Depends on nothing; every other file of the block but gffr_ram imports it.
`default_nettype none

package gffr_pkg;

   // Grid capacity.
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;

   // Derived widths.
   localparam int IDX_W     = $clog2(CELL_CAP);       // cell address
   localparam int LOAD_W    = $clog2(CELL_CAP + 1);   // cell count, holds CELL_CAP
   localparam int ROW_DIM_W = $clog2(MAX_ROWS + 1);   // clamped row count
   localparam int COL_DIM_W = $clog2(MAX_COLS + 1);   // clamped column count
   localparam int COL_W     = $clog2(MAX_COLS);       // column position

   // Fixed field widths.
   localparam int CFG_W     = 6;
   localparam int KIND_W    = 2;
   localparam int COUNT_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Grid memory word: wall flag and visited flag.
   localparam int WORD_W    = 2;
   localparam int WALL_BIT  = 1;
   localparam int VISIT_BIT = 0;

   typedef enum logic [KIND_W-1:0] {
      KIND_OPEN  = 2'd0,
      KIND_WALL  = 2'd1,
      KIND_START = 2'd2
   } cell_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_COUNT = 2'd0,
      REG_COL_COUNT = 2'd1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_AREA,
      ST_CHECK,
      ST_RUN,
      ST_TURN,
      ST_DONE
   } fill_state_type;

   // Control of the delay chain that holds the last row of visited flags.
   typedef struct packed {
      logic clear;
      logic shift;
   } chain_ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/gffr_if.sv */
// Valid/ready channel interfaces of the flood fill block: cell input,
// count output and register write port. Depends on gffr_pkg.
`default_nettype none

interface gffr_req_if import gffr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] cell_kind;
   logic              last_cell;

   modport source (output valid, output cell_kind, output last_cell, input ready);
   modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

interface gffr_rsp_if import gffr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] reachable_count;

   modport source (output valid, output reachable_count, input ready);
   modport sink   (input valid, input reachable_count, output ready);
endinterface

interface gffr_csr_if import gffr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/grid_flood_fill_reach_count.sv */
// Grid flood fill reach counter, top level. Depends on gffr_pkg, gffr_if,
// gffr_ram, gffr_chain and gffr_cell.
//
// Usage: cell words arrive on req_bus in row-major order, one per cycle while
// ready is high. A word with last_cell set closes the grid; the block then
// stops taking words, floods the 4-connected open region around the first
// start cell and sends one word with reachable_count on rsp_bus (0 if there
// is no start cell inside the grid in use).
// Grid size comes from the row and column count registers on csr_bus, which
// always takes writes at once; write them only while no grid is in flight.
// After the last cell: the area and check states set up the sweep, then sweeps
// run over the grid of L cells (L = loaded cells, at most rows * cols), forward
// and backward in turn, until a sweep after the first adds no cell; at least two
// sweeps, none without a start in the grid in use. Each sweep reads and writes
// the grid memory once per cell. The done state then loads the count word into
// the output register once that register is free.
// Throughput: one cell word per cycle while loading.
// Reset: registers go to 32 rows and 32 columns and the loader empties.
// A stalled receiver holds the count word in the output register; the next
// grid may load meanwhile, and its count waits until that word is taken.
`default_nettype none

module grid_flood_fill_reach_count import gffr_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   gffr_req_if.sink  req_bus,
   gffr_rsp_if.source rsp_bus,
   gffr_csr_if.sink  csr_bus
);

   fill_state_type     state_ff, state_in;
   logic [CFG_W-1:0]   row_count_ff, row_count_in;
   logic [CFG_W-1:0]   col_count_ff, col_count_in;
   logic [LOAD_W-1:0]  load_index_ff, load_index_in;
   logic [IDX_W-1:0]   start_index_ff, start_index_in;
   logic               start_found_ff, start_found_in;
   logic [LOAD_W-1:0]  area_ff, area_in;
   logic [LOAD_W-1:0]  limit_ff, limit_in;
   logic               backward_ff, backward_in;
   logic               first_pass_ff, first_pass_in;
   logic [LOAD_W-1:0]  issued_ff, issued_in;
   logic [COL_W-1:0]   issue_col_ff, issue_col_in;
   logic [COL_W-1:0]   last_col_ff, last_col_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]   s1_addr_ff, s1_addr_in;
   logic [COL_W-1:0]   s1_col_ff, s1_col_in;
   logic               prev_ff, prev_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               changed_ff, changed_in;
   logic [COUNT_W-1:0] result_ff, result_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [ROW_DIM_W-1:0] rows;
   logic [COL_DIM_W-1:0] cols;
   logic [COL_W-1:0]     cols_m1;
   logic                 req_accept;
   logic [LOAD_W-1:0]    back_offset;
   logic [IDX_W-1:0]     issue_addr;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [WORD_W-1:0]    ram_rdata;
   logic                 seed_vis;
   logic                 side_vis;
   logic                 tap_vis;
   logic                 new_vis;
   chain_ctrl_type       chain_ctrl;

   // Register values outside 1..max act as the nearest bound.
   always_comb begin
      if (row_count_ff == '0) begin
         rows = ROW_DIM_W'(1);
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         rows = ROW_DIM_W'(MAX_ROWS);
      end else begin
         rows = ROW_DIM_W'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         cols = COL_DIM_W'(1);
      end else if (int'(col_count_ff) > MAX_COLS) begin
         cols = COL_DIM_W'(MAX_COLS);
      end else begin
         cols = COL_DIM_W'(col_count_ff);
      end
   end

   assign cols_m1 = COL_W'(cols - COL_DIM_W'(1));

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.reachable_count = rsp_count_ff;

   // Forward sweeps run up from cell 0, backward sweeps down from the last.
   assign back_offset = limit_ff - issued_ff - LOAD_W'(1);
   assign issue_addr  = backward_ff ? back_offset[IDX_W-1:0] : issued_ff[IDX_W-1:0];

   gffr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELL_CAP)
   ) u_ram (
      .clock,
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_addr),
      .rd_data (ram_rdata)
   );

   gffr_chain u_chain (
      .clock,
      .ctrl    (chain_ctrl),
      .bit_in  (new_vis),
      .tap_sel (cols_m1),
      .tap_out (tap_vis)
   );

   // A cell is reached if it is open and it, its row neighbor just swept or
   // its column neighbor one row back in sweep order is reached. The first
   // sweep starts from the start cell alone, which clears the old map.
   always_comb begin
      seed_vis = first_pass_ff ? (s1_addr_ff == start_index_ff) : ram_rdata[VISIT_BIT];
      if (backward_ff) begin
         side_vis = prev_ff && (s1_col_ff != cols_m1);
      end else begin
         side_vis = prev_ff && (s1_col_ff != '0);
      end
      new_vis = !ram_rdata[WALL_BIT] && (seed_vis || side_vis || tap_vis);
   end

   always_comb begin
      state_in       = state_ff;
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      load_index_in  = load_index_ff;
      start_index_in = start_index_ff;
      start_found_in = start_found_ff;
      area_in        = area_ff;
      limit_in       = limit_ff;
      backward_in    = backward_ff;
      first_pass_in  = first_pass_ff;
      issued_in      = issued_ff;
      issue_col_in   = issue_col_ff;
      last_col_in    = last_col_ff;
      s1_valid_in    = 1'b0;
      s1_addr_in     = s1_addr_ff;
      s1_col_in      = s1_col_ff;
      prev_in        = prev_ff;
      count_in       = count_ff;
      changed_in     = changed_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = s1_addr_ff;
      ram_wdata      = {ram_rdata[WALL_BIT], new_vis};
      chain_ctrl     = '{clear: 1'b0, shift: 1'b0};

      if (csr_bus.valid) begin
         if (csr_bus.index == REG_ROW_COUNT) begin
            row_count_in = csr_bus.data;
         end else if (csr_bus.index == REG_COL_COUNT) begin
            col_count_in = csr_bus.data;
         end
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Second stage of a sweep: the memory word of the cell read last cycle.
      if (s1_valid_ff) begin
         ram_we           = 1'b1;
         chain_ctrl.shift = 1'b1;
         prev_in          = new_vis;
         if (new_vis && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if (new_vis != seed_vis) begin
            changed_in = 1'b1;
         end
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               if (int'(load_index_ff) < CELL_CAP) begin
                  ram_we        = 1'b1;
                  ram_waddr     = load_index_ff[IDX_W-1:0];
                  ram_wdata     = {(req_bus.cell_kind == KIND_WALL), 1'b0};
                  load_index_in = load_index_ff + LOAD_W'(1);
                  if ((req_bus.cell_kind == KIND_START) && !start_found_ff) begin
                     start_found_in = 1'b1;
                     start_index_in = load_index_ff[IDX_W-1:0];
                  end
               end
               if (req_bus.last_cell) begin
                  state_in = ST_AREA;
               end
            end
         end
         ST_AREA: begin
            area_in  = LOAD_W'(rows) * LOAD_W'(cols);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            limit_in = (area_ff < load_index_ff) ? area_ff : load_index_ff;
            if (start_found_ff && (LOAD_W'(start_index_ff) < area_ff)
                && (LOAD_W'(start_index_ff) < load_index_ff)) begin
               backward_in      = 1'b0;
               first_pass_in    = 1'b1;
               issued_in        = '0;
               issue_col_in     = '0;
               prev_in          = 1'b0;
               count_in         = '0;
               changed_in       = 1'b0;
               chain_ctrl.clear = 1'b1;
               state_in         = ST_RUN;
            end else begin
               result_in = '0;
               state_in  = ST_DONE;
            end
         end
         ST_RUN: begin
            if (issued_ff < limit_ff) begin
               s1_valid_in = 1'b1;
               s1_addr_in  = issue_addr;
               s1_col_in   = issue_col_ff;
               issued_in   = issued_ff + LOAD_W'(1);
               if (backward_ff) begin
                  issue_col_in = (issue_col_ff == '0) ? cols_m1 : issue_col_ff - COL_W'(1);
               end else begin
                  issue_col_in = (issue_col_ff == cols_m1) ? '0 : issue_col_ff + COL_W'(1);
                  // Column of the final cell, where backward sweeps begin.
                  if (issued_ff == limit_ff - LOAD_W'(1)) begin
                     last_col_in = issue_col_ff;
                  end
               end
            end else if (!s1_valid_ff) begin
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            if (!changed_ff && !first_pass_ff) begin
               result_in = count_ff;
               state_in  = ST_DONE;
            end else begin
               backward_in      = !backward_ff;
               first_pass_in    = 1'b0;
               issued_in        = '0;
               issue_col_in     = backward_ff ? '0 : last_col_ff;
               prev_in          = 1'b0;
               count_in         = '0;
               changed_in       = 1'b0;
               chain_ctrl.clear = 1'b1;
               state_in         = ST_RUN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = result_ff;
               load_index_in  = '0;
               start_found_in = 1'b0;
               state_in       = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         row_count_ff   <= CFG_W'(MAX_ROWS);
         col_count_ff   <= CFG_W'(MAX_COLS);
         load_index_ff  <= '0;
         start_found_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         load_index_ff  <= load_index_in;
         start_found_ff <= start_found_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_index_ff <= start_index_in;
      area_ff        <= area_in;
      limit_ff       <= limit_in;
      backward_ff    <= backward_in;
      first_pass_ff  <= first_pass_in;
      issued_ff      <= issued_in;
      issue_col_ff   <= issue_col_in;
      last_col_ff    <= last_col_in;
      s1_addr_ff     <= s1_addr_in;
      s1_col_ff      <= s1_col_in;
      prev_ff        <= prev_in;
      count_ff       <= count_in;
      changed_ff     <= changed_in;
      result_ff      <= result_in;
      rsp_count_ff   <= rsp_count_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/gffr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module gffr_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/gffr_cell.sv */
// One stage of the visited-flag delay chain: holds one flag and passes it on.
// Depends on gffr_pkg.
`default_nettype none

module gffr_cell import gffr_pkg::*; (
   input  wire logic           clock,
   input  wire chain_ctrl_type ctrl,
   input  wire logic           d,
   output logic                q
);

   logic flag_ff;
   logic flag_in;

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.clear) begin
         flag_in = 1'b0;
      end else if (ctrl.shift) begin
         flag_in = d;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
   end

   assign q = flag_ff;

endmodule

`default_nettype wire

/* hw/rtl/gffr_chain.sv */
// Row of MAX_COLS delay stages carrying the visited flags of the cells most
// recently swept; the tap returns the flag one grid row back. Uses gffr_cell.
`default_nettype none

module gffr_chain import gffr_pkg::*; (
   input  wire logic             clock,
   input  wire chain_ctrl_type   ctrl,
   input  wire logic             bit_in,
   input  wire logic [COL_W-1:0] tap_sel,
   output logic                  tap_out
);

   logic [MAX_COLS-1:0] stage_q;

   for (genvar g = 0; g < MAX_COLS; g++) begin : g_node
      if (g == 0) begin : g_head
         gffr_cell u_node (.clock, .ctrl, .d(bit_in), .q(stage_q[g]));
      end else begin : g_body
         gffr_cell u_node (.clock, .ctrl, .d(stage_q[g-1]), .q(stage_q[g]));
      end
   end

   // Stage k holds the flag swept k+1 cells ago.
   assign tap_out = stage_q[tap_sel];

endmodule

`default_nettype wire
